// ===== src/srs_pkg.sv =====
package srs_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned LIM_W  = 23;   // 16-bit register times 100
	localparam int unsigned IDX_W  = 2;

	// commands carried in the op field of an input word
	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_INC  = 3'd1,
		CMD_DEC  = 3'd2,
		CMD_OFF  = 3'd3,
		CMD_BACK = 3'd4
	} cmd_t;

	// running operation, also the completion event code
	typedef enum logic [1:0] {
		OPR_NONE = 2'd0,
		OPR_INC  = 2'd1,
		OPR_DEC  = 2'd2,
		OPR_OFF  = 2'd3
	} opr_t;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SPEED_WAIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_OFF_WAIT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_RESP_WAIT  = 2'd2;

	// reset values of the registers, already scaled to milliseconds
	localparam logic [LIM_W-1:0] SPEED_LIM_RST = 23'd400;
	localparam logic [LIM_W-1:0] OFF_LIM_RST   = 23'd40000;
	localparam logic [LIM_W-1:0] RESP_LIM_RST  = 23'd25000;

	typedef struct packed {
		logic [LIM_W-1:0] speed_lim;
		logic [LIM_W-1:0] off_lim;
		logic [LIM_W-1:0] resp_lim;
	} lim_t;

	typedef struct packed {
		logic [2:0] op;
		logic       slow_end;
		logic       fast_end;
	} item_t;

	typedef struct packed {
		logic       power_relay;
		logic       slow_relay;
		logic       fast_relay;
		opr_t       response_event;
		opr_t       active_operation;
		logic       backing_off;
	} res_t;

	// scale a register in 100 ms units to milliseconds: x*64 + x*32 + x*4
	function automatic logic [LIM_W-1:0] scale_ms(input logic [CFG_W-1:0] x);
		logic [LIM_W-1:0] w;
		w = {{(LIM_W-CFG_W){1'b0}}, x};
		return (w << 6) + (w << 5) + (w << 2);
	endfunction

endpackage

// ===== src/srs_cfg.sv =====
module srs_cfg
	import srs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output lim_t             lim
);

	lim_t lim_q;

	// hold each limit already scaled to milliseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.speed_lim <= SPEED_LIM_RST;
			lim_q.off_lim   <= OFF_LIM_RST;
			lim_q.resp_lim  <= RESP_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_WAIT: lim_q.speed_lim <= scale_ms(cfg_data);
				REG_OFF_WAIT:   lim_q.off_lim   <= scale_ms(cfg_data);
				REG_RESP_WAIT:  lim_q.resp_lim  <= scale_ms(cfg_data);
				default: ;
			endcase
		end
	end

	assign lim = lim_q;

endmodule

// ===== src/srs_core.sv =====
module srs_core
	import srs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  item_t item,
	input  lim_t  lim,
	output res_t  res
);

	logic [TIME_W-1:0] now_q, speed_start_q, off_start_q, resp_start_q, bo_start_q, run_time_q;
	opr_t              operation_q;
	logic              operating_q, pending_q, bo_q, abn_q;
	logic [2:0]        relay_q;   // bit0 power, bit1 slow, bit2 fast

	logic [TIME_W-1:0] now_d, speed_start_d, off_start_d, resp_start_d, bo_start_d, run_time_d;
	opr_t              operation_d;
	logic              operating_d, pending_d, bo_d, abn_d;
	logic [2:0]        relay_d;
	opr_t              event_d;

	always_comb begin
		logic [TIME_W-1:0] bo_limit;
		logic              expired;
		now_d         = now_q;
		speed_start_d = speed_start_q;
		off_start_d   = off_start_q;
		resp_start_d  = resp_start_q;
		bo_start_d    = bo_start_q;
		run_time_d    = run_time_q;
		operation_d   = operation_q;
		operating_d   = operating_q;
		pending_d     = pending_q;
		bo_d          = bo_q;
		abn_d         = abn_q;
		relay_d       = relay_q;
		event_d       = OPR_NONE;
		bo_limit      = '0;
		expired       = 1'b0;

		case (item.op)
			CMD_TICK: begin
				now_d = now_q + 32'd1;
				// timeout of the running operation
				if (operating_q) begin
					if (operation_q == OPR_OFF)
						expired = (now_d - off_start_q) >= {9'd0, lim.off_lim};
					else
						expired = (now_d - speed_start_q) >= {9'd0, lim.speed_lim};
				end
				if (expired) begin
					relay_d = 3'b000;
					if (operation_q == OPR_OFF)
						run_time_d = now_d - off_start_q;
					operating_d  = 1'b0;
					resp_start_d = now_d;
					pending_d    = 1'b1;
				end
				// delayed completion event
				if (pending_d && ((now_d - resp_start_d) >= {9'd0, lim.resp_lim})) begin
					event_d   = operation_q;
					pending_d = 1'b0;
				end
				// end of back-off
				if (bo_q) begin
					bo_limit = abn_q ? run_time_d : {9'd0, lim.off_lim};
					if ((now_d - bo_start_q) >= bo_limit) begin
						relay_d = 3'b000;
						bo_d    = 1'b0;
						abn_d   = 1'b0;
					end
				end
				// limit switch hit
				if (item.slow_end || item.fast_end) begin
					relay_d = 3'b000;
					if (!bo_d) begin
						if (operation_q == OPR_OFF)
							run_time_d = now_d - off_start_q;
						operating_d  = 1'b0;
						resp_start_d = now_d;
						pending_d    = 1'b1;
						abn_d        = 1'b1;
					end else begin
						bo_d  = 1'b0;
						abn_d = 1'b0;
					end
				end
			end
			CMD_INC: begin
				operation_d   = OPR_INC;
				relay_d       = 3'b101;
				speed_start_d = now_q;
				operating_d   = 1'b1;
			end
			CMD_DEC: begin
				operation_d   = OPR_DEC;
				relay_d       = 3'b011;
				speed_start_d = now_q;
				operating_d   = 1'b1;
			end
			CMD_OFF: begin
				operation_d = OPR_OFF;
				relay_d     = 3'b011;
				off_start_d = now_q;
				operating_d = 1'b1;
			end
			CMD_BACK: begin
				relay_d    = 3'b101;
				bo_d       = 1'b1;
				bo_start_d = now_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			speed_start_q <= '0;
			off_start_q   <= '0;
			resp_start_q  <= '0;
			bo_start_q    <= '0;
			run_time_q    <= '0;
			operation_q   <= OPR_NONE;
			operating_q   <= 1'b0;
			pending_q     <= 1'b0;
			bo_q          <= 1'b0;
			abn_q         <= 1'b0;
			relay_q       <= 3'b000;
		end else if (adv) begin
			now_q         <= now_d;
			speed_start_q <= speed_start_d;
			off_start_q   <= off_start_d;
			resp_start_q  <= resp_start_d;
			bo_start_q    <= bo_start_d;
			run_time_q    <= run_time_d;
			operation_q   <= operation_d;
			operating_q   <= operating_d;
			pending_q     <= pending_d;
			bo_q          <= bo_d;
			abn_q         <= abn_d;
			relay_q       <= relay_d;
		end
	end

	assign res.power_relay      = relay_d[0];
	assign res.slow_relay       = relay_d[1];
	assign res.fast_relay       = relay_d[2];
	assign res.response_event   = event_d;
	assign res.active_operation = operating_d ? operation_d : OPR_NONE;
	assign res.backing_off      = bo_d;

endmodule

// ===== src/speed_relay_sequencer.sv =====
// A word accepted into the input register is processed by the core and its result word is
// loaded into the output register, where it is held until taken.
// Throughput: one word per cycle while the output register is free or being emptied.
// Reset (arst_n low, asynchronous): both stages empty, all relays off, no operation,
// millisecond count zero, limits back to 0.4 s, 40 s and 25 s.
module speed_relay_sequencer
	import srs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [2:0] op, [3] slow_end, [4] fast_end, [7:5] zero
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [0] power_relay, [1] slow_relay, [2] fast_relay,
	                                    // [4:3] response_event, [6:5] active_operation,
	                                    // [7] backing_off
	// configuration writes
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	item_t      item_s1;
	logic       valid_s1;
	logic       adv;
	lim_t       lim;
	res_t       res;
	logic [7:0] out_q;
	logic       out_valid_q;

	// Advance the held word into the core whenever the output register is free
	// or being emptied this cycle; the output register parts the two sides.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op       <= s_tdata[2:0];
			item_s1.slow_end <= s_tdata[3];
			item_s1.fast_end <= s_tdata[4];
		end
	end

	srs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lim       (lim)
	);

	// The core commits its state at the same edge that the result is loaded,
	// so each word sees everything left by the word before it.
	srs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.lim    (lim),
		.res    (res)
	);

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {res.backing_off, res.active_operation, res.response_event,
			          res.fast_relay, res.slow_relay, res.power_relay};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
